// File: rtl/core/cbsfp_pkg.sv
// Shared types, constants and the CRC table function of the frame packer.
`timescale 1ns / 1ps

package cbsfp_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BUS_ADDRESS  = 3'd0,
    REG_CONTROL_BASE = 3'd1,
    REG_CRC_POLY     = 3'd2,
    REG_HEAD_BYTE    = 3'd3,
    REG_ESCAPE_BYTE  = 3'd4,
    REG_ESCAPE_ALT   = 3'd5
  } reg_index_t;

  // One queued item, already classified by the front part.
  typedef struct packed {
    logic       first;
    logic       last;
    logic       has_byte;
    logic [7:0] opcode;
    logic [7:0] len_byte;
    logic [7:0] ctrl_byte;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  bus_address;
    logic [7:0]  control_base;
    logic [15:0] crc_polynomial;
    logic [7:0]  head_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  escape_alt_byte;
  } cfg_t;

  // MSB-first CRC-16 table entry for one index byte.
  function automatic logic [15:0] crc_table_entry(input logic [7:0] idx,
                                                  input logic [15:0] poly);
    logic [15:0] r;
    r = {idx, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ poly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/cbsfp_front.sv
// Front part: accepts items, tracks frame state and sequence number, queues work.
`timescale 1ns / 1ps

module cbsfp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,
  input  logic               in_tlast,
  input  logic [1:0]         in_tuser,
  input  logic [7:0]         control_base,
  input  logic               q_full,
  output logic               q_push,
  output cbsfp_pkg::item_t   q_item
);
  import cbsfp_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [3:0] seq_r, seq_nxt;
  logic       accept, live, first, has_byte;

  assign first     = in_tuser[0];
  assign has_byte  = in_tuser[1];
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign live      = first || in_frame_r;

  // Drop items outside a frame and frame items that produce nothing.
  assign q_push = accept && live && (first || has_byte || in_tlast);

  always_comb begin
    q_item.first     = first;
    q_item.last      = in_tlast;
    q_item.has_byte  = has_byte;
    q_item.opcode    = in_tdata[7:0];
    q_item.len_byte  = in_tdata[15:8] + 8'd1;
    q_item.ctrl_byte = control_base + {4'd0, seq_r};
    q_item.data      = in_tdata[23:16];
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    seq_nxt      = seq_r;
    if (accept && live) begin
      if (in_tlast) begin
        in_frame_nxt = 1'b0;
        seq_nxt      = seq_r + 4'd1;
      end else begin
        in_frame_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      seq_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      seq_r      <= seq_nxt;
    end
  end

endmodule

// File: rtl/core/cbsfp_fifo.sv
// Short item queue between the front and back parts.
`timescale 1ns / 1ps

module cbsfp_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cbsfp_pkg::item_t wr_item,
  input  logic             pop,
  output cbsfp_pkg::item_t rd_item,
  output logic             not_empty,
  output logic             full
);
  import cbsfp_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == (QAW + 1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/cbsfp_back.sv
// Back part: walks each item's frame bytes, runs the CRC, stuffs and emits bytes.
`timescale 1ns / 1ps

module cbsfp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cbsfp_pkg::cfg_t  cfg,
  input  cbsfp_pkg::item_t item,
  input  logic             item_valid,
  output logic             item_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic [0:0]       out_tuser
);
  import cbsfp_pkg::*;

  typedef enum logic [7:0] {
    ST_HEAD = 8'b0000_0001,
    ST_ADDR = 8'b0000_0010,
    ST_CTRL = 8'b0000_0100,
    ST_LEN  = 8'b0000_1000,
    ST_OPC  = 8'b0001_0000,
    ST_DATA = 8'b0010_0000,
    ST_CRCH = 8'b0100_0000,
    ST_CRCL = 8'b1000_0000
  } step_t;

  step_t       step_r, step_nxt, start_step, cur_step, next_step;
  logic        busy_r, busy_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  pend_byte_r, pend_byte_nxt;
  logic        pend_run_r, pend_run_nxt, pend_frame_r, pend_frame_nxt;
  logic        oval_r, oval_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        orun_r, orun_nxt, oframe_r, oframe_nxt;

  logic [7:0]  cur_byte, first_out, second_out;
  logic        final_step, feeds_crc, is_head, is_esc, two;
  logic        slot_free, emit_pend, fire;

  always_comb begin
    if (item.first) begin
      start_step = ST_HEAD;
    end else if (item.has_byte) begin
      start_step = ST_DATA;
    end else begin
      start_step = ST_CRCH;
    end
  end

  assign cur_step = busy_r ? step_r : start_step;

  always_comb begin
    cur_byte   = cfg.head_byte;
    next_step  = ST_HEAD;
    final_step = 1'b0;
    feeds_crc  = 1'b0;
    case (cur_step)
      ST_HEAD: begin
        cur_byte  = cfg.head_byte;
        next_step = ST_ADDR;
      end
      ST_ADDR: begin
        cur_byte  = cfg.bus_address;
        feeds_crc = 1'b1;
        next_step = ST_CTRL;
      end
      ST_CTRL: begin
        cur_byte  = item.ctrl_byte;
        feeds_crc = 1'b1;
        next_step = ST_LEN;
      end
      ST_LEN: begin
        cur_byte  = item.len_byte;
        feeds_crc = 1'b1;
        next_step = ST_OPC;
      end
      ST_OPC: begin
        cur_byte  = item.opcode;
        feeds_crc = 1'b1;
        if (item.has_byte) begin
          next_step = ST_DATA;
        end else if (item.last) begin
          next_step = ST_CRCH;
        end else begin
          final_step = 1'b1;
        end
      end
      ST_DATA: begin
        cur_byte  = item.data;
        feeds_crc = 1'b1;
        if (item.last) begin
          next_step = ST_CRCH;
        end else begin
          final_step = 1'b1;
        end
      end
      ST_CRCH: begin
        cur_byte  = crc_r[15:8];
        next_step = ST_CRCL;
      end
      ST_CRCL: begin
        cur_byte   = crc_r[7:0];
        final_step = 1'b1;
      end
      default: begin
        cur_byte = cfg.head_byte;
      end
    endcase
  end

  // Head test first; the head byte itself goes out unstuffed.
  assign is_head    = (cur_step != ST_HEAD) && (cur_byte == cfg.head_byte);
  assign is_esc     = (cur_step != ST_HEAD) && !is_head && (cur_byte == cfg.escape_byte);
  assign two        = is_head || is_esc;
  assign first_out  = two ? cfg.escape_byte : cur_byte;
  assign second_out = is_head ? cfg.escape_byte : cfg.escape_alt_byte;

  assign slot_free = !oval_r || out_tready;
  assign emit_pend = slot_free && pend_r;
  assign fire      = slot_free && !pend_r && item_valid;
  assign item_pop  = fire && final_step;

  always_comb begin
    busy_nxt       = busy_r;
    step_nxt       = step_r;
    crc_nxt        = crc_r;
    pend_nxt       = pend_r;
    pend_byte_nxt  = pend_byte_r;
    pend_run_nxt   = pend_run_r;
    pend_frame_nxt = pend_frame_r;
    oval_nxt       = oval_r && !out_tready;
    obyte_nxt      = obyte_r;
    orun_nxt       = orun_r;
    oframe_nxt     = oframe_r;
    if (emit_pend) begin
      pend_nxt   = 1'b0;
      oval_nxt   = 1'b1;
      obyte_nxt  = pend_byte_r;
      orun_nxt   = pend_run_r;
      oframe_nxt = pend_frame_r;
    end else if (fire) begin
      busy_nxt   = !final_step;
      step_nxt   = next_step;
      oval_nxt   = 1'b1;
      obyte_nxt  = first_out;
      orun_nxt   = final_step && !two;
      oframe_nxt = (cur_step == ST_CRCL) && !two;
      if (two) begin
        pend_nxt       = 1'b1;
        pend_byte_nxt  = second_out;
        pend_run_nxt   = final_step;
        pend_frame_nxt = (cur_step == ST_CRCL);
      end
      if (cur_step == ST_HEAD || cur_step == ST_CRCL) begin
        crc_nxt = CRC_INIT;
      end else if (feeds_crc) begin
        crc_nxt = {crc_r[7:0], 8'h00}
                ^ crc_table_entry(crc_r[15:8] ^ cur_byte, cfg.crc_polynomial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_HEAD;
      crc_r  <= CRC_INIT;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      crc_r  <= crc_nxt;
      pend_r <= pend_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r  <= pend_byte_nxt;
    pend_run_r   <= pend_run_nxt;
    pend_frame_r <= pend_frame_nxt;
    obyte_r      <= obyte_nxt;
    orun_r       <= orun_nxt;
    oframe_r     <= oframe_nxt;
  end

  assign out_tvalid   = oval_r;
  assign out_tdata    = obyte_r;
  assign out_tlast    = orun_r;
  assign out_tuser[0] = oframe_r;

endmodule

// File: rtl/core/crc16_byte_stuffed_frame_packer_core.sv
// Top level of the byte-stuffed frame packer with CRC-16.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid / in_tready   tdata {data,len,opcode}, tlast, tuser {has,first}
// out_     master     out_tvalid / out_tready tdata line byte, tlast run end, tuser frame end
// cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// The back part walks each item's line bytes in order: a body item gives its data byte,
// an opening item first gives head, address, control, length and opcode bytes, and a
// closing item ends with the two CRC bytes; a stuffed byte goes out as two line bytes.
// The four-entry item queue lets the front keep taking items while the back works;
// the input stalls only when that queue is full.
// The output byte register holds its value while out_tready is low.
// Reset (rst_n low, synchronous) empties the queue, closes any frame, zeroes the
// sequence number and loads register defaults.

module crc16_byte_stuffed_frame_packer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] opcode_byte, [15:8] payload_length, [23:16] data_byte
  input  logic        in_tlast,
  input  logic [1:0]  in_tuser,   // [0] first, [1] has_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cbsfp_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t q_wr_item, q_rd_item;
  logic  q_push, q_pop, q_not_empty, q_full;

  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_BUS_ADDRESS:  cfg_nxt.bus_address     = cfg_data[7:0];
        REG_CONTROL_BASE: cfg_nxt.control_base    = cfg_data[7:0];
        REG_CRC_POLY:     cfg_nxt.crc_polynomial  = cfg_data;
        REG_HEAD_BYTE:    cfg_nxt.head_byte       = cfg_data[7:0];
        REG_ESCAPE_BYTE:  cfg_nxt.escape_byte     = cfg_data[7:0];
        REG_ESCAPE_ALT:   cfg_nxt.escape_alt_byte = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_address     <= 8'h00;
      cfg_r.control_base    <= 8'h00;
      cfg_r.crc_polynomial  <= 16'h1021;
      cfg_r.head_byte       <= 8'hAA;
      cfg_r.escape_byte     <= 8'hAB;
      cfg_r.escape_alt_byte <= 8'hAC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify items and drop those that produce nothing.
  cbsfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .in_tuser     (in_tuser),
    .control_base (cfg_r.control_base),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_wr_item)
  );

  cbsfp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (q_wr_item),
    .pop       (q_pop),
    .rd_item   (q_rd_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: expand each item into stuffed line bytes.
  cbsfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (q_rd_item),
    .item_valid (q_not_empty),
    .item_pop   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/core/cbsfp_checker.sv
// Port-level checks for the frame packer and their binding to the top level.
`timescale 1ns / 1ps

module cbsfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tlast) && $stable(out_tuser))
    else $error("output byte changed while stalled");

  // The frame's final byte always ends its item's run.
  a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end without run end");

  // Nothing is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind crc16_byte_stuffed_frame_packer_core cbsfp_checker u_cbsfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
